// File: sv/shb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shb_pkg;

   typedef logic [31:0] shb_word_type;

   localparam int unsigned ROUND_COUNT = 64;
   localparam int unsigned HASH_WORDS  = 8;
   localparam int unsigned SCHED_WORDS = 16;
   localparam int unsigned BLOCK_BITS  = 512;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [7:0] PAD_ZERO   = 8'h00;
   localparam logic [5:0] LEN_OFFSET = 6'd56;
   localparam logic [5:0] FILL_LAST  = 6'd63;
   localparam logic [2:0] WORD_LAST  = 3'd7;

   localparam shb_word_type INIT_HASH [HASH_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam shb_word_type ROUND_K [ROUND_COUNT] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BLOCK,
      ST_PAD,
      ST_PAD_WAIT,
      ST_LEN,
      ST_FINAL_WAIT,
      ST_EMIT
   } shb_state_type;

   typedef struct packed {
      logic start;
      logic init;
   } shb_core_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } shb_core_stat_type;

   function automatic shb_word_type rotr(input shb_word_type x, input logic [4:0] n);
      return (x >> n) | (x << (6'd32 - {1'b0, n}));
   endfunction

endpackage

`default_nettype wire

// File: sv/shb_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface shb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, output data_byte, output byte_present,
                   output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input byte_present,
                   input end_of_message, output ready);
endinterface

`default_nettype wire

// File: sv/shb_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface shb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        last_word;

   modport source (output valid, output digest_word, output last_word, input ready);
   modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

`default_nettype wire

// File: sv/shb_compress.sv
`timescale 1ns / 1ps
`default_nettype none

module shb_compress (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire shb_pkg::shb_core_ctrl_type       ctrl,
   input  wire logic [shb_pkg::BLOCK_BITS-1:0]   block,
   output shb_pkg::shb_core_stat_type            stat,
   output shb_pkg::shb_word_type                 hash_words [shb_pkg::HASH_WORDS]
);

   logic                  busy_ff, busy_in;
   logic                  fin_ff, fin_in;
   logic [5:0]            round_ff, round_in;
   shb_pkg::shb_word_type h_ff [shb_pkg::HASH_WORDS];
   shb_pkg::shb_word_type h_in [shb_pkg::HASH_WORDS];
   shb_pkg::shb_word_type v_ff [shb_pkg::HASH_WORDS];
   shb_pkg::shb_word_type v_in [shb_pkg::HASH_WORDS];
   shb_pkg::shb_word_type w_ff [shb_pkg::SCHED_WORDS];
   shb_pkg::shb_word_type w_in [shb_pkg::SCHED_WORDS];
   shb_pkg::shb_word_type t1, t2, w_new, sig0, sig1;

   always_comb begin
      sig0  = shb_pkg::rotr(w_ff[1], 5'd7) ^ shb_pkg::rotr(w_ff[1], 5'd18) ^ (w_ff[1] >> 3);
      sig1  = shb_pkg::rotr(w_ff[14], 5'd17) ^ shb_pkg::rotr(w_ff[14], 5'd19)
              ^ (w_ff[14] >> 10);
      w_new = sig1 + w_ff[9] + sig0 + w_ff[0];
      t1 = v_ff[7]
           + (shb_pkg::rotr(v_ff[4], 5'd6) ^ shb_pkg::rotr(v_ff[4], 5'd11)
              ^ shb_pkg::rotr(v_ff[4], 5'd25))
           + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
           + shb_pkg::ROUND_K[round_ff] + w_ff[0];
      t2 = (shb_pkg::rotr(v_ff[0], 5'd2) ^ shb_pkg::rotr(v_ff[0], 5'd13)
            ^ shb_pkg::rotr(v_ff[0], 5'd22))
           + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

      busy_in  = busy_ff;
      fin_in   = 1'b0;
      round_in = round_ff;
      h_in     = h_ff;
      v_in     = v_ff;
      w_in     = w_ff;

      if (ctrl.start) begin
         busy_in  = 1'b1;
         round_in = '0;
         v_in     = h_ff;
         for (int i = 0; i < shb_pkg::SCHED_WORDS; i++) begin
            w_in[i] = block[shb_pkg::BLOCK_BITS-1-32*i -: 32];
         end
      end else if (busy_ff) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         for (int i = 0; i < shb_pkg::SCHED_WORDS - 1; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[shb_pkg::SCHED_WORDS-1] = w_new;
         round_in = round_ff + 6'd1;
         if (round_ff == 6'(shb_pkg::ROUND_COUNT - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end

      if (fin_ff) begin
         for (int i = 0; i < shb_pkg::HASH_WORDS; i++) begin
            h_in[i] = h_ff[i] + v_ff[i];
         end
      end
      if (ctrl.init) begin
         h_in = shb_pkg::INIT_HASH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         fin_ff   <= 1'b0;
         round_ff <= '0;
         h_ff     <= shb_pkg::INIT_HASH;
      end else begin
         busy_ff  <= busy_in;
         fin_ff   <= fin_in;
         round_ff <= round_in;
         h_ff     <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      w_ff <= w_in;
   end

   assign stat.busy  = busy_ff | fin_ff;
   assign stat.done  = fin_ff;
   assign hash_words = h_ff;

endmodule

`default_nettype wire

// File: sv/sha256_byte_stream_hasher_top.sv
// SHA-256 over a byte stream. Each request transaction carries at most one message byte and an
// end-of-message mark; the eight digest words follow as response transactions, high word
// first, and the hasher then starts the next message from the initial hash values. Bytes are
// taken one per cycle while the hasher is idle into a 64-byte block shift register; the 64th
// byte starts one shared round unit, which runs one round per cycle, and a full block holds
// off requests through the start, the 64 rounds and the hash update. The final transaction
// shifts in the 0x80 mark, zero bytes up to byte 56 and the 64-bit bit length (through a
// second block when needed), then runs one final compression and then emits the digest
// words. No request is taken from the end mark until the last digest word has been accepted.
`timescale 1ns / 1ps
`default_nettype none

module sha256_byte_stream_hasher_top (
   input wire logic  clock,
   input wire logic  reset,
   shb_req_if.sink   req_chan,
   shb_rsp_if.source rsp_chan
);

   shb_pkg::shb_state_type     state_ff, state_in;
   logic [5:0]                 fill_ff, fill_in;
   logic [63:0]                total_ff, total_in;
   logic [shb_pkg::BLOCK_BITS-1:0] block_ff, block_in;
   logic                       first_ff, first_in;
   logic                       pend_ff, pend_in;
   logic                       start_ff, start_in;
   logic [2:0]                 idx_ff, idx_in;
   logic                       shift_en;
   logic [7:0]                 shift_byte;
   logic                       full;
   shb_pkg::shb_core_ctrl_type core_ctrl;
   shb_pkg::shb_core_stat_type core_stat;
   shb_pkg::shb_word_type      hash_words [shb_pkg::HASH_WORDS];

   shb_compress u_compress (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (core_ctrl),
      .block      (block_ff),
      .stat       (core_stat),
      .hash_words (hash_words)
   );

   always_comb begin
      state_in        = state_ff;
      total_in        = total_ff;
      first_in        = first_ff;
      pend_in         = pend_ff;
      idx_in          = idx_ff;
      shift_en        = 1'b0;
      shift_byte      = shb_pkg::PAD_ZERO;
      core_ctrl.start = start_ff;
      core_ctrl.init  = 1'b0;
      req_chan.ready  = 1'b0;
      rsp_chan.valid  = 1'b0;

      case (state_ff)
         shb_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               pend_in  = req_chan.end_of_message;
               first_in = 1'b1;
               if (req_chan.byte_present) begin
                  shift_en   = 1'b1;
                  shift_byte = req_chan.data_byte;
                  total_in   = total_ff + 64'd1;
               end
               if (req_chan.byte_present && fill_ff == shb_pkg::FILL_LAST) begin
                  state_in = shb_pkg::ST_BLOCK;
               end else if (req_chan.end_of_message) begin
                  state_in = shb_pkg::ST_PAD;
               end
            end
         end
         shb_pkg::ST_BLOCK: begin
            if (core_stat.done) begin
               state_in = pend_ff ? shb_pkg::ST_PAD : shb_pkg::ST_IDLE;
            end
         end
         shb_pkg::ST_PAD: begin
            if (!first_ff && fill_ff == shb_pkg::LEN_OFFSET) begin
               state_in = shb_pkg::ST_LEN;
               total_in = {total_ff[60:0], 3'b000};
            end else begin
               shift_en   = 1'b1;
               shift_byte = first_ff ? shb_pkg::PAD_MARK : shb_pkg::PAD_ZERO;
               first_in   = 1'b0;
               if (fill_ff == shb_pkg::FILL_LAST) begin
                  state_in = shb_pkg::ST_PAD_WAIT;
               end
            end
         end
         shb_pkg::ST_PAD_WAIT: begin
            if (core_stat.done) begin
               state_in = shb_pkg::ST_PAD;
            end
         end
         shb_pkg::ST_LEN: begin
            shift_en   = 1'b1;
            shift_byte = total_ff[63:56];
            total_in   = {total_ff[55:0], 8'h00};
            if (fill_ff == shb_pkg::FILL_LAST) begin
               state_in = shb_pkg::ST_FINAL_WAIT;
            end
         end
         shb_pkg::ST_FINAL_WAIT: begin
            idx_in = '0;
            if (core_stat.done) begin
               state_in = shb_pkg::ST_EMIT;
            end
         end
         shb_pkg::ST_EMIT: begin
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == shb_pkg::WORD_LAST) begin
                  core_ctrl.init = 1'b1;
                  total_in       = '0;
                  state_in       = shb_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = shb_pkg::ST_IDLE;
         end
      endcase

      full     = shift_en && fill_ff == shb_pkg::FILL_LAST;
      start_in = full;
      fill_in  = shift_en ? fill_ff + 6'd1 : fill_ff;
      block_in = shift_en ? {block_ff[shb_pkg::BLOCK_BITS-9:0], shift_byte} : block_ff;

      rsp_chan.digest_word = hash_words[idx_ff];
      rsp_chan.last_word   = idx_ff == shb_pkg::WORD_LAST;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= shb_pkg::ST_IDLE;
         fill_ff  <= '0;
         total_ff <= '0;
         first_ff <= 1'b0;
         pend_ff  <= 1'b0;
         start_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
         first_ff <= first_in;
         pend_ff  <= pend_in;
         start_ff <= start_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
   end

   // round unit must be idle when a block is handed over
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      core_ctrl.start |-> !core_stat.busy)
      else $error("block start while round unit busy");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("request taken during digest output");

   a_emit_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> fill_ff == '0 && !core_stat.busy)
      else $error("digest output with block not closed");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.last_word |=>
         req_chan.ready && total_ff == '0)
      else $error("hasher not restarted after digest");

endmodule

`default_nettype wire
